// ===== src/aes_pkg.sv =====
// shared types, s-box tables and round functions of the aes-256 unit
package aes_pkg;

  localparam int unsigned BLK_W   = 128;
  localparam int unsigned HALF_W  = 64;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned ROUNDS  = 14;
  localparam int unsigned ROWS    = ROUNDS + 1;
  localparam int unsigned ROW_W   = $clog2(ROWS);
  localparam int unsigned WORDS   = 4 * ROWS;
  localparam int unsigned WIDX_W  = $clog2(WORDS);
  localparam int unsigned KEY_REGS = 4;
  localparam int unsigned CIDX_W  = 3;

  localparam logic [CIDX_W-1:0] REG_KEY_HIGH     = 3'd0;
  localparam logic [CIDX_W-1:0] REG_KEY_MID_HIGH = 3'd1;
  localparam logic [CIDX_W-1:0] REG_KEY_MID_LOW  = 3'd2;
  localparam logic [CIDX_W-1:0] REG_KEY_LOW      = 3'd3;

  localparam logic [ROW_W-1:0] ROW_FIRST = '0;
  localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROUNDS);

  typedef logic [BLK_W-1:0]  block_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ROW_W-1:0]  row_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic first;
    logic last;
    logic dec;
    logic step;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
  } stat_t;

  localparam logic [2047:0] SBOX_TBL = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  localparam logic [2047:0] INV_SBOX_TBL = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
  };

  function automatic logic [7:0] sbox(input logic [7:0] x);
    sbox = SBOX_TBL[{~x, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    inv_sbox = INV_SBOX_TBL[{~x, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // multiply by a 4-bit constant in gf(2^8)
  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] c);
    logic [7:0] p;
    logic [7:0] m;
    p = '0;
    m = a;
    for (int i = 0; i < 4; i++) begin
      if (c[i]) p ^= m;
      m = xtime(m);
    end
    gmul = p;
  endfunction

  function automatic logic [7:0] get_byte(input block_t s, input int unsigned i);
    get_byte = s[BLK_W-1-8*i -: 8];
  endfunction

  function automatic block_t sub_bytes(input block_t s, input logic inv);
    block_t t;
    for (int i = 0; i < 16; i++) begin
      t[8*i +: 8] = inv ? inv_sbox(s[8*i +: 8]) : sbox(s[8*i +: 8]);
    end
    sub_bytes = t;
  endfunction

  function automatic block_t shift_rows(input block_t s, input logic inv);
    block_t t;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[BLK_W-1-8*(r+4*c) -: 8] = inv ? get_byte(s, r + 4*((c + 4 - r) % 4))
                                        : get_byte(s, r + 4*((c + r) % 4));
      end
    end
    shift_rows = t;
  endfunction

  function automatic block_t mix_columns(input block_t s, input logic inv);
    block_t t;
    logic [3:0] m [4];
    logic [7:0] acc;
    if (inv) begin
      m[0] = 4'd14; m[1] = 4'd11; m[2] = 4'd13; m[3] = 4'd9;
    end else begin
      m[0] = 4'd2;  m[1] = 4'd3;  m[2] = 4'd1;  m[3] = 4'd1;
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = '0;
        for (int k = 0; k < 4; k++) begin
          acc ^= gmul(get_byte(s, 4*c + k), m[(k + 4 - r) % 4]);
        end
        t[BLK_W-1-8*(4*c+r) -: 8] = acc;
      end
    end
    mix_columns = t;
  endfunction

  function automatic word_t sub_word(input word_t w);
    word_t t;
    for (int k = 0; k < 4; k++) t[8*k +: 8] = sbox(w[8*k +: 8]);
    sub_word = t;
  endfunction

endpackage

// ===== src/aes256_block_cipher_unit.sv =====
// top level of the aes-256 block cipher unit
// AES-256 ECB engine: one 128-bit item at a time, in_operation 0 encrypts and 1 decrypts.
// An item goes from acceptance to the result register in steps: the block is loaded at the
// accepting edge, then 15 passes through the single shared round unit (initial key addition
// plus 14 rounds, one per cycle, paced by the one-row-per-cycle round-key memory) and a
// hand-over to the output register. A new item is accepted only once the controller is
// back in idle after it; a result still waiting in the output register holds the hand-over.
// The key is written through cfg_* (index 0..3, first key byte most significant); each
// write, and reset, starts a key expansion of all 60 schedule words, one schedule word per
// cycle, during which no item is accepted. Writes to other indexes are ignored.
module aes256_block_cipher_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [aes_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [aes_pkg::HALF_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_operation,
  input  logic [aes_pkg::HALF_W-1:0]  in_block_high,
  input  logic [aes_pkg::HALF_W-1:0]  in_block_low,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [aes_pkg::HALF_W-1:0]  out_result_high,
  output logic [aes_pkg::HALF_W-1:0]  out_result_low
);
  import aes_pkg::*;

  cmd_t   cmd;
  stat_t  stat;
  row_t   rd_addr;
  block_t round_key;
  logic   key_busy;

  aes_ksched u_ksched (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .rd_addr   (rd_addr),
    .rd_data   (round_key),
    .busy      (key_busy)
  );

  aes_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .key_busy     (key_busy),
    .stat         (stat),
    .cmd          (cmd),
    .rd_addr      (rd_addr)
  );

  aes_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_block_high   (in_block_high),
    .in_block_low    (in_block_low),
    .round_key       (round_key),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_high (out_result_high),
    .out_result_low  (out_result_low)
  );

endmodule

// ===== src/aes_ksched.sv =====
// key registers, key expansion sequencer and round-key memory
module aes_ksched (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [aes_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [aes_pkg::HALF_W-1:0]    cfg_wdata,
  input  aes_pkg::row_t                 rd_addr,
  output aes_pkg::block_t               rd_data,
  output logic                          busy
);
  import aes_pkg::*;

  logic [HALF_W-1:0] key_r [KEY_REGS];
  word_t             win_r [8];
  logic [WIDX_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [7:0]        rc_r, rc_nxt;
  block_t            mem [ROWS];
  block_t            rd_data_r;
  word_t             new_word;
  word_t             t;
  logic [HALF_W-1:0] kreg;
  logic              restart;

  assign restart = cfg_we && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_MID_HIGH ||
                              cfg_index == REG_KEY_MID_LOW || cfg_index == REG_KEY_LOW);

  // w[i-1] sits in win_r[7], w[i-8] in win_r[0]
  always_comb begin
    kreg = key_r[cnt_r[2:1]];
    t = win_r[7];
    if (cnt_r[2:0] == 3'd0) begin
      t = sub_word({win_r[7][23:0], win_r[7][31:24]}) ^ {rc_r, 24'h0};
    end else if (cnt_r[2:0] == 3'd4) begin
      t = sub_word(win_r[7]);
    end
    if (cnt_r < WIDX_W'(8)) begin
      new_word = cnt_r[0] ? kreg[WORD_W-1:0] : kreg[HALF_W-1:WORD_W];
    end else begin
      new_word = win_r[0] ^ t;
    end
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    rc_nxt   = rc_r;
    if (restart) begin
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      rc_nxt   = 8'h01;
    end else if (busy_r) begin
      if (cnt_r >= WIDX_W'(8) && cnt_r[2:0] == 3'd0) rc_nxt = xtime(rc_r);
      if (cnt_r == WIDX_W'(WORDS - 1)) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b1;
      rc_r   <= 8'h01;
      for (int i = 0; i < KEY_REGS; i++) key_r[i] <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      rc_r   <= rc_nxt;
      if (restart) key_r[cfg_index[1:0]] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && !restart) begin
      for (int i = 0; i < 7; i++) win_r[i] <= win_r[i+1];
      win_r[7] <= new_word;
      // a row is complete every fourth word
      if (cnt_r[1:0] == 2'd3) begin
        mem[cnt_r[WIDX_W-1:2]] <= {win_r[5], win_r[6], win_r[7], new_word};
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;
  assign busy    = busy_r;

endmodule

// ===== src/aes_ctrl.sv =====
// round sequencer state machine
module aes_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_operation,
  output logic            in_ready,
  input  logic            key_busy,
  input  aes_pkg::stat_t  stat,
  output aes_pkg::cmd_t   cmd,
  output aes_pkg::row_t   rd_addr
);
  import aes_pkg::*;

  state_t     state_r, state_nxt;
  row_t       rnd_r, rnd_nxt;
  logic       dec_r, dec_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r   <= '0;
      dec_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      dec_r   <= dec_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    dec_nxt   = dec_r;
    in_ready  = 1'b0;
    cmd       = '0;
    rd_addr   = ROW_FIRST;
    cmd.dec   = dec_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = !key_busy;
        rd_addr  = in_operation ? ROW_LAST : ROW_FIRST;
        if (in_valid && !key_busy) begin
          cmd.load  = 1'b1;
          dec_nxt   = in_operation;
          rnd_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step  = 1'b1;
        cmd.first = (rnd_r == ROW_FIRST);
        cmd.last  = (rnd_r == ROW_LAST);
        // fetch the key row of the next round
        if (rnd_r != ROW_LAST) begin
          rd_addr = dec_r ? (ROW_LAST - rnd_r - 1'b1) : (rnd_r + 1'b1);
        end
        if (rnd_r == ROW_LAST) begin
          state_nxt = ST_DONE;
        end else begin
          rnd_nxt = rnd_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== src/aes_dp.sv =====
// cipher state register, shared round unit and output register
module aes_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  aes_pkg::cmd_t               cmd,
  output aes_pkg::stat_t              stat,
  input  logic [aes_pkg::HALF_W-1:0]  in_block_high,
  input  logic [aes_pkg::HALF_W-1:0]  in_block_low,
  input  aes_pkg::block_t             round_key,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [aes_pkg::HALF_W-1:0]  out_result_high,
  output logic [aes_pkg::HALF_W-1:0]  out_result_low
);
  import aes_pkg::*;

  block_t s_r, s_nxt;
  block_t out_r;
  logic   out_valid_r, out_valid_nxt;
  block_t t;
  block_t u;

  always_comb begin
    t = cmd.dec ? sub_bytes(shift_rows(s_r, 1'b1), 1'b1)
                : shift_rows(sub_bytes(s_r, 1'b0), 1'b0);
    if (cmd.dec) begin
      u = t ^ round_key;
      if (!cmd.last) u = mix_columns(u, 1'b1);
    end else begin
      u = cmd.last ? t : mix_columns(t, 1'b0);
      u = u ^ round_key;
    end
    s_nxt = s_r;
    if (cmd.load) begin
      s_nxt = {in_block_high, in_block_low};
    end else if (cmd.step) begin
      s_nxt = cmd.first ? (s_r ^ round_key) : u;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt;
    if (cmd.out_load) out_r <= s_r;
  end

  assign stat.out_busy   = out_valid_r && !out_ready;
  assign out_valid       = out_valid_r;
  assign out_result_high = out_r[BLK_W-1:HALF_W];
  assign out_result_low  = out_r[HALF_W-1:0];

endmodule

// ===== sim/aes256_block_cipher_checker.sv =====
// scoreboard for the aes-256 unit: tracks the key, predicts every block and compares results
`timescale 1ns / 1ps

module aes256_block_cipher_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [aes_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [aes_pkg::HALF_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        in_operation,
  input  logic [aes_pkg::HALF_W-1:0]  in_block_high,
  input  logic [aes_pkg::HALF_W-1:0]  in_block_low,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [aes_pkg::HALF_W-1:0]  out_result_high,
  input  logic [aes_pkg::HALF_W-1:0]  out_result_low,
  output int                          errors,
  output int                          pending,
  output int                          blocks_checked
);
  import aes_pkg::*;

  logic [7:0]        fwd_sb [256];
  logic [7:0]        inv_sb [256];
  logic [HALF_W-1:0] key_reg [KEY_REGS];
  logic [31:0]       sched [60];
  logic [127:0]      expected_blocks [$];

  function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
    return (x << n) | (x >> (8 - n));
  endfunction

  // s-box from the field inverse and the affine map
  initial begin
    logic [7:0] r, b, sq;
    for (int x = 0; x < 256; x++) begin
      r = 8'h01;
      sq = x[7:0];
      for (int e = 254; e != 0; e >>= 1) begin
        if (e & 1) r = gf_mult(r, sq);
        sq = gf_mult(sq, sq);
      end
      b = r ^ rotl8(r, 1) ^ rotl8(r, 2) ^ rotl8(r, 3) ^ rotl8(r, 4) ^ 8'h63;
      fwd_sb[x] = b;
      inv_sb[b] = x[7:0];
    end
  end

  function automatic logic [31:0] subst_word(input logic [31:0] w);
    return {fwd_sb[w[31:24]], fwd_sb[w[23:16]], fwd_sb[w[15:8]], fwd_sb[w[7:0]]};
  endfunction

  function void build_schedule();
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    for (int i = 0; i < KEY_REGS; i++) begin
      sched[2*i]   = key_reg[i][63:32];
      sched[2*i+1] = key_reg[i][31:0];
    end
    for (int i = 8; i < 60; i++) begin
      t = sched[i-1];
      if (i % 8 == 0) begin
        t = subst_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gf_mult(rc, 8'h02);
      end else if (i % 8 == 4) begin
        t = subst_word(t);
      end
      sched[i] = sched[i-8] ^ t;
    end
  endfunction

  // byte i of the state sits at bits 127-8i down
  function automatic logic [127:0] add_rk(input logic [127:0] v, input int rnd);
    return v ^ {sched[4*rnd], sched[4*rnd+1], sched[4*rnd+2], sched[4*rnd+3]};
  endfunction

  function automatic logic [127:0] subst_state(input logic [127:0] v, input logic dec);
    logic [127:0] t;
    for (int i = 0; i < 16; i++) t[8*i +: 8] = dec ? inv_sb[v[8*i +: 8]] : fwd_sb[v[8*i +: 8]];
    return t;
  endfunction

  function automatic logic [127:0] shift_state(input logic [127:0] v, input logic dec);
    logic [127:0] t;
    int src, dst;
    t = v;
    for (int r = 1; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        src = dec ? r + 4*c : r + 4*((c + r) % 4);
        dst = dec ? r + 4*((c + r) % 4) : r + 4*c;
        t[127-8*dst -: 8] = v[127-8*src -: 8];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_state(input logic [127:0] v, input logic dec);
    logic [127:0] t;
    logic [7:0]   coef [4];
    logic [7:0]   acc;
    if (dec) coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else     coef = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = '0;
        for (int k = 0; k < 4; k++) acc ^= gf_mult(v[127-8*(4*c+k) -: 8], coef[(k + 4 - r) % 4]);
        t[127-8*(4*c+r) -: 8] = acc;
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] cipher_block(input logic dec, input logic [127:0] blk);
    logic [127:0] s;
    if (!dec) begin
      s = add_rk(blk, 0);
      for (int r = 1; r < ROUNDS; r++)
        s = add_rk(mix_state(shift_state(subst_state(s, 1'b0), 1'b0), 1'b0), r);
      s = add_rk(shift_state(subst_state(s, 1'b0), 1'b0), ROUNDS);
    end else begin
      s = add_rk(blk, ROUNDS);
      for (int r = ROUNDS - 1; r >= 1; r--)
        s = mix_state(add_rk(subst_state(shift_state(s, 1'b1), 1'b1), r), 1'b1);
      s = add_rk(subst_state(shift_state(s, 1'b1), 1'b1), 0);
    end
    return s;
  endfunction

  always @(posedge clk) begin
    logic [127:0] want;
    if (!rst_n) begin
      foreach (key_reg[i]) key_reg[i] = '0;
      build_schedule();
      expected_blocks.delete();
      errors <= 0;
      blocks_checked <= 0;
    end else begin
      if (cfg_we && cfg_index < CIDX_W'(KEY_REGS)) begin
        key_reg[cfg_index] = cfg_wdata;
        build_schedule();
      end
      if (in_valid && in_ready)
        expected_blocks.push_back(cipher_block(in_operation, {in_block_high, in_block_low}));
      if (out_valid && out_ready) begin
        blocks_checked <= blocks_checked + 1;
        if (expected_blocks.size() == 0) begin
          if (errors < 10) $display("unexpected item %h_%h", out_result_high, out_result_low);
          errors <= errors + 1;
        end else begin
          want = expected_blocks.pop_front();
          if (want != {out_result_high, out_result_low}) begin
            if (errors < 10)
              $display("mismatch: expected high %h low %h, got high %h low %h",
                       want[127:64], want[63:0], out_result_high, out_result_low);
            errors <= errors + 1;
          end
        end
      end
    end
    pending <= expected_blocks.size();
  end

endmodule

// ===== sim/aes256_block_cipher_unit_tb.sv =====
// top of the aes-256 unit testbench: clock, reset, stimulus, receiver and verdict
`timescale 1ns / 1ps

module aes256_block_cipher_unit_tb;
  import aes_pkg::*;

  localparam int IDLE_LIMIT  = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN       = 40;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [HALF_W-1:0] cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_operation = 1'b0;
  logic [HALF_W-1:0] in_block_high = '0;
  logic [HALF_W-1:0] in_block_low = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [HALF_W-1:0] out_result_high;
  logic [HALF_W-1:0] out_result_low;

  int errors, pending, blocks_checked;
  int blocks_sent = 0;
  int key_loads = 0;
  int idle_cycles = 0;
  int rx_pct = 100;
  int stall_asks = 0;
  int stall_served = 0;
  int hold_left = 0;

  aes256_block_cipher_unit dut (.*);

  aes256_block_cipher_checker checker_i (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: random stalls plus one long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_served != stall_asks) begin
      stall_served <= stall_asks;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) < rx_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [HALF_W-1:0] rand_half();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 8) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic send_block(input logic op, input logic [HALF_W-1:0] hi,
                            input logic [HALF_W-1:0] lo);
    int g;
    in_valid <= 1'b1;
    in_operation <= op;
    in_block_high <= hi;
    in_block_low <= lo;
    do @(posedge clk); while (!in_ready);
    blocks_sent++;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [HALF_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // drain, let the engine settle, then write the whole key
  task automatic load_key(input logic [HALF_W-1:0] k0, input logic [HALF_W-1:0] k1,
                          input logic [HALF_W-1:0] k2, input logic [HALF_W-1:0] k3);
    wait_drained();
    repeat (DRAIN) @(posedge clk);
    write_reg(REG_KEY_HIGH, k0);
    write_reg(REG_KEY_MID_HIGH, k1);
    write_reg(REG_KEY_MID_LOW, k2);
    write_reg(REG_KEY_LOW, k3);
    key_loads++;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all-zero key after reset
    send_block(1'b0, '0, '0);
    send_block(1'b1, '0, '0);
    send_block(1'b0, '1, '1);
    send_block(1'b1, '1, '1);

    load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, 64'h18191a1b1c1d1e1f);
    // writes past the last key register must leave the key alone
    write_reg(CIDX_W'(KEY_REGS), '1);
    write_reg(CIDX_W'(KEY_REGS + 3), 64'h5a5a5a5a5a5a5a5a);
    send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(1'b1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
    send_block(1'b0, 64'h8000000000000000, 64'h0000000000000001);
    send_block(1'b1, 64'ha5a5a5a5a5a5a5a5, 64'h5a5a5a5a5a5a5a5a);
    send_block(1'b0, '0, '1);
    send_block(1'b1, '1, '0);

    load_key('1, '1, '1, '1);
    send_block(1'b0, '0, '0);
    send_block(1'b1, '0, '0);
    send_block(1'b0, '1, '1);
    send_block(1'b1, 64'h0123456789abcdef, 64'hfedcba9876543210);

    // a single key register changed on its own
    wait_drained();
    repeat (DRAIN) @(posedge clk);
    write_reg(REG_KEY_MID_LOW, 64'h0f1e2d3c4b5a6978);
    send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(1'b1, 64'h0011223344556677, 64'h8899aabbccddeeff);

    for (int ph = 0; ph < 8; ph++) begin
      load_key(rand_half(), rand_half(), rand_half(), rand_half());
      case (ph % 4)
        0: rx_pct = 100;
        1: rx_pct = 75;
        2: rx_pct = 40;
        default: rx_pct = 90;
      endcase
      if (ph == 2) stall_asks++;
      for (int n = 0; n < 200; n++) begin
        if (ph == 4 && n == 100) wait_drained();
        send_block(1'($urandom_range(0, 1)), rand_half(), rand_half());
      end
    end

    wait_drained();
    repeat (DRAIN) @(posedge clk);
    $display("covered %0d blocks, both directions, over %0d key loads and the reset key",
             blocks_sent, key_loads);
    $display("results checked: %0d, mismatches: %0d", blocks_checked, errors);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/aes_pkg.sv
src/aes_ksched.sv
src/aes_ctrl.sv
src/aes_dp.sv
src/aes256_block_cipher_unit.sv
sim/aes256_block_cipher_checker.sv
sim/aes256_block_cipher_unit_tb.sv
